// ===== sv/gfed_pkg.sv =====
// ----------------------------------------------------------------------------
// gfed_pkg
// Shared types, constants and generator tables for the GF(2) erasure decoder.
// ----------------------------------------------------------------------------
package gfed_pkg;

  localparam int unsigned POSITION_BITS = 16;

  localparam logic [2:0] REG_DATA_STRINGS = 3'd0;
  localparam logic [2:0] REG_ROW_FIRST    = 3'd1;
  localparam logic [2:0] REG_ROW_SECOND   = 3'd2;
  localparam logic [2:0] REG_ROW_THIRD    = 3'd3;
  localparam logic [2:0] REG_MESSAGE_BITS = 3'd4;

  typedef struct packed {
    logic [2:0] recv_third;
    logic [2:0] recv_second;
    logic [2:0] recv_first;
  } in_item_t;

  typedef struct packed {
    logic       singular;
    logic       last_chunk;
    logic       chunk_wide;
    logic [2:0] data_third;
    logic [2:0] data_second;
    logic [2:0] data_first;
  } out_item_t;

  // Classified chunk handed from the front to the back.
  typedef struct packed {
    in_item_t recv;
    logic     wide;
    logic     last;
  } job_t;

  typedef struct packed {
    logic [1:0]  data_strings;
    logic [2:0]  row_first;
    logic [2:0]  row_second;
    logic [2:0]  row_third;
    logic [15:0] message_bits;
  } cfg_t;

  typedef enum logic [1:0] {
    INV_IDLE,
    INV_NARROW,
    INV_WIDE,
    INV_DONE
  } inv_state_e;

  // Generator row mask for one bit of one coded row.
  function automatic logic [8:0] gen_mask(input logic three, input logic wide,
                                          input logic [2:0] row, input logic [1:0] bit_i);
    logic [8:0] m;
    m = '0;
    if (!three) begin
      if (wide) begin
        unique case (row[1:0])
          2'd0: m = 9'd1 << bit_i;
          2'd1: m = 9'd8 << bit_i;
          2'd2: m = 9'd9 << bit_i;
          default: m = (bit_i == 2'd2) ? 9'd35 : (9'd10 << bit_i);
        endcase
      end else begin
        unique case (row[1:0])
          2'd0: m = 9'd1 << bit_i[0];
          2'd1: m = 9'd4 << bit_i[0];
          2'd2: m = 9'd5 << bit_i[0];
          default: m = bit_i[0] ? 9'd11 : 9'd6;
        endcase
      end
    end else begin
      if (wide) begin
        unique case (row)
          3'd0: m = 9'd1 << bit_i;
          3'd1: m = 9'd8 << bit_i;
          3'd2: m = 9'd64 << bit_i;
          3'd3: m = 9'd73 << bit_i;
          default: m = (bit_i == 2'd0) ? 9'd83 : (bit_i == 2'd1) ? 9'd166 : 9'd287;
        endcase
      end else begin
        unique case (row)
          3'd0: m = 9'd1 << bit_i[0];
          3'd1: m = 9'd4 << bit_i[0];
          3'd2: m = 9'd16 << bit_i[0];
          3'd3: m = 9'd21 << bit_i[0];
          default: m = bit_i[0] ? 9'd45 : 9'd27;
        endcase
      end
    end
    return m;
  endfunction

endpackage

// ===== sv/gfed_inverter.sv =====
// ----------------------------------------------------------------------------
// gfed_inverter
// Sequential Gauss-Jordan inversion over GF(2), one pivot column a cycle.
// ----------------------------------------------------------------------------
module gfed_inverter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  gfed_pkg::cfg_t       cfg_i,
  output logic                 done_o,
  output logic                 bad_o,
  output logic [5:0][5:0]      inv_narrow_o,
  output logic [8:0][8:0]      inv_wide_o
);
  import gfed_pkg::*;

  inv_state_e state_q, state_d;
  logic [8:0][17:0] aug_q, aug_d;
  logic [3:0] col_q, col_d;
  logic       loaded_q, loaded_d;
  logic       bad_q, bad_d;
  logic [5:0][5:0] nar_q, nar_d;
  logic [8:0][8:0] wid_q, wid_d;

  logic three, wide_phase;
  logic [3:0] n;
  logic [3:0] piv;
  logic       found;
  logic [17:0] prow;
  logic [2:0] rows [3];
  logic [2:0] lim_bad;

  assign three = (cfg_i.data_strings != 2'd2);
  assign wide_phase = (state_q == INV_WIDE);
  assign rows[0] = cfg_i.row_first;
  assign rows[1] = cfg_i.row_second;
  assign rows[2] = cfg_i.row_third;

  always_comb begin
    lim_bad[0] = three ? (rows[0] > 3'd4) : (rows[0] > 3'd3);
    lim_bad[1] = three ? (rows[1] > 3'd4) : (rows[1] > 3'd3);
    lim_bad[2] = three ? (rows[2] > 3'd4) : 1'b0;
  end

  always_comb begin
    unique case ({three, wide_phase})
      2'b00: n = 4'd4;
      2'b01: n = 4'd6;
      2'b10: n = 4'd6;
      default: n = 4'd9;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= INV_IDLE;
      col_q    <= '0;
      loaded_q <= 1'b0;
      bad_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      loaded_q <= loaded_d;
      bad_q    <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aug_q <= aug_d;
    nar_q <= nar_d;
    wid_q <= wid_d;
  end

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    loaded_d = loaded_q;
    bad_d    = bad_q;
    aug_d    = aug_q;
    nar_d    = nar_q;
    wid_d    = wid_q;
    piv      = 4'd0;
    found    = 1'b0;
    prow     = '0;
    unique case (state_q)
      INV_IDLE: begin
        if (start_i) begin
          state_d  = INV_NARROW;
          loaded_d = 1'b0;
          bad_d    = |lim_bad;
          nar_d    = '0;
          wid_d    = '0;
        end
      end
      INV_NARROW, INV_WIDE: begin
        if (start_i) begin
          state_d  = INV_NARROW;
          loaded_d = 1'b0;
          bad_d    = |lim_bad;
        end else if (bad_q) begin
          nar_d   = '0;
          wid_d   = '0;
          state_d = INV_DONE;
        end else if (!loaded_q) begin
          // load augmented matrix [G | I], identity placed at bit n
          for (int k = 0; k < 9; k++) begin
            aug_d[k] = '0;
            if (4'(k) < n) begin
              if (wide_phase)
                aug_d[k][8:0] = gen_mask(three, 1'b1, rows[k / 3], 2'(k % 3));
              else
                aug_d[k][8:0] = gen_mask(three, 1'b0, rows[k / 2], 2'(k % 2));
              aug_d[k] = aug_d[k] | (18'd1 << ({1'b0, n} + 5'(k)));
            end
          end
          col_d    = '0;
          loaded_d = 1'b1;
        end else if (col_q == n) begin
          for (int k = 0; k < 9; k++) begin
            if (wide_phase) wid_d[k] = 9'(aug_q[k] >> n);
            else if (k < 6) nar_d[k] = 6'(aug_q[k] >> n);
          end
          loaded_d = 1'b0;
          state_d  = wide_phase ? INV_DONE : INV_WIDE;
        end else begin
          for (int r = 8; r >= 0; r--) begin
            if (4'(r) >= col_q && 4'(r) < n && aug_q[r][col_q]) begin
              piv   = 4'(r);
              found = 1'b1;
            end
          end
          if (!found) begin
            bad_d   = 1'b1;
            nar_d   = '0;
            wid_d   = '0;
            state_d = INV_DONE;
          end else begin
            prow = aug_q[piv];
            aug_d[piv] = aug_q[col_q];
            aug_d[col_q] = prow;
            for (int r = 0; r < 9; r++) begin
              if (4'(r) != col_q && aug_d[r][col_q]) aug_d[r] = aug_d[r] ^ prow;
            end
            col_d = col_q + 4'd1;
          end
        end
      end
      default: begin
        if (start_i) begin
          state_d  = INV_NARROW;
          loaded_d = 1'b0;
          bad_d    = |lim_bad;
        end
      end
    endcase
  end

  assign done_o       = (state_q == INV_DONE) && !start_i;
  assign bad_o        = bad_q;
  assign inv_narrow_o = nar_q;
  assign inv_wide_o   = wid_q;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= 4'd9) else $error("pivot column out of range");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == INV_DONE && bad_q) |-> (nar_q == '0 && wid_q == '0))
    else $error("singular inverse not cleared");
  a_start_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> state_q == INV_NARROW) else $error("start did not restart");
`endif
endmodule

// ===== sv/gfed_front.sv =====
// ----------------------------------------------------------------------------
// gfed_front
// Accepts chunks, tracks message position and classifies chunk size.
// ----------------------------------------------------------------------------
module gfed_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic               inv_done_i,
  input  logic [15:0]        message_bits_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gfed_pkg::in_item_t in_data_i,
  output logic               job_valid_o,
  input  logic               job_full_i,
  output gfed_pkg::job_t     job_o
);
  import gfed_pkg::*;

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS:0]   pos3, posw;
  logic wide, last, take;

  assign in_stall_o  = job_full_i || !inv_done_i;
  assign take        = in_valid_i && !in_stall_o;
  assign job_valid_o = take;
  assign pos3 = {1'b0, pos_q} + (POSITION_BITS+1)'(3);
  assign wide = (pos3 == (POSITION_BITS+1)'(message_bits_i));
  assign posw = {1'b0, pos_q} + (wide ? (POSITION_BITS+1)'(3) : (POSITION_BITS+1)'(2));
  assign last = (posw >= (POSITION_BITS+1)'(message_bits_i));

  always_comb begin
    job_o.recv = in_data_i;
    job_o.wide = wide;
    job_o.last = last;
    pos_d = pos_q;
    if (restart_i) pos_d = '0;
    else if (take) pos_d = last ? '0 : posw[POSITION_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_q <= '0;
    else pos_q <= pos_d;
  end
endmodule

// ===== sv/gfed_back.sv =====
// ----------------------------------------------------------------------------
// gfed_back
// Two-entry job queue and GF(2) matrix-vector product into an output register.
// ----------------------------------------------------------------------------
module gfed_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_full_o,
  input  gfed_pkg::job_t      job_i,
  input  logic                three_i,
  input  logic                bad_i,
  input  logic [5:0][5:0]     inv_narrow_i,
  input  logic [8:0][8:0]     inv_wide_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gfed_pkg::out_item_t out_data_o
);
  import gfed_pkg::*;

  job_t q_mem [2];
  logic [1:0] cnt_q;
  logic rd_q, wr_q;
  logic out_v_q;
  out_item_t out_q, res;
  logic pop, push, load;
  job_t head;
  logic [8:0] y, d;

  assign job_full_o = (cnt_q == 2'd2);
  assign push = job_valid_i;
  assign load = !out_v_q || !out_stall_i;
  assign pop  = (cnt_q != 2'd0) && load;
  assign head = q_mem[rd_q];

  always_comb begin
    y = '0;
    if (head.wide) begin
      y[2:0] = head.recv.recv_first;
      y[5:3] = head.recv.recv_second;
      y[8:6] = three_i ? head.recv.recv_third : 3'd0;
    end else begin
      y[1:0] = head.recv.recv_first[1:0];
      y[3:2] = head.recv.recv_second[1:0];
      y[5:4] = three_i ? head.recv.recv_third[1:0] : 2'd0;
    end
    d = '0;
    for (int k = 0; k < 9; k++) begin
      if (head.wide) d[k] = ^(inv_wide_i[k] & y);
      else if (k < 6) d[k] = ^(inv_narrow_i[k] & y[5:0]);
    end
    res = '0;
    res.chunk_wide = head.wide;
    res.last_chunk = head.last;
    res.singular   = bad_i;
    if (!bad_i) begin
      if (head.wide) begin
        res.data_first  = d[2:0];
        res.data_second = d[5:3];
        res.data_third  = three_i ? d[8:6] : 3'd0;
      end else begin
        res.data_first  = {1'b0, d[1:0]};
        res.data_second = {1'b0, d[3:2]};
        res.data_third  = three_i ? {1'b0, d[5:4]} : 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= job_i;
    if (pop) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (load) out_v_q <= pop;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("job queue overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> (out_v_q && $stable(out_q)))
    else $error("stalled result changed");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> cnt_q != 2'd2) else $error("push into full queue");
`endif
endmodule

// ===== sv/gf2_erasure_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// gf2_erasure_decoder_unit
// Erasure decoder: front classifies chunks, back multiplies by the inverse.
// ----------------------------------------------------------------------------
// Path: accepted chunk -> job queue -> GF(2) product -> output register.
// Throughput: one chunk per cycle unless the output stalls or the inverter is busy.
// After reset or any register write the inverter runs (one pivot column a cycle,
// both chunk sizes) while input is stalled.
// Reset: asynchronous active low; registers return to their defaults.
module gf2_erasure_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gfed_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gfed_pkg::out_item_t out_data_o
);
  import gfed_pkg::*;

  cfg_t cfg_q;
  logic wr, start_q, done, bad, job_valid, job_full;
  logic [5:0][5:0] inv_n;
  logic [8:0][8:0] inv_w;
  job_t job;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{data_strings: 2'd3, row_first: 3'd0, row_second: 3'd1,
                   row_third: 3'd2, message_bits: 16'd2};
      start_q <= 1'b1;
    end else begin
      start_q <= wr;
      if (wr) begin
        unique case (paddr[4:2])
          REG_DATA_STRINGS: cfg_q.data_strings <= pwdata[1:0];
          REG_ROW_FIRST:    cfg_q.row_first    <= pwdata[2:0];
          REG_ROW_SECOND:   cfg_q.row_second   <= pwdata[2:0];
          REG_ROW_THIRD:    cfg_q.row_third    <= pwdata[2:0];
          REG_MESSAGE_BITS: cfg_q.message_bits <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_DATA_STRINGS: prdata = 32'(cfg_q.data_strings);
      REG_ROW_FIRST:    prdata = 32'(cfg_q.row_first);
      REG_ROW_SECOND:   prdata = 32'(cfg_q.row_second);
      REG_ROW_THIRD:    prdata = 32'(cfg_q.row_third);
      REG_MESSAGE_BITS: prdata = 32'(cfg_q.message_bits);
      default:          prdata = '0;
    endcase
  end

  gfed_inverter u_inv (
    .clk_i, .rst_ni, .start_i(start_q || wr), .cfg_i(cfg_q),
    .done_o(done), .bad_o(bad), .inv_narrow_o(inv_n), .inv_wide_o(inv_w)
  );

  gfed_front u_front (
    .clk_i, .rst_ni, .restart_i(wr), .inv_done_i(done),
    .message_bits_i(cfg_q.message_bits), .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(job_valid), .job_full_i(job_full), .job_o(job)
  );

  gfed_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_full_o(job_full), .job_i(job),
    .three_i(cfg_q.data_strings != 2'd2), .bad_i(bad),
    .inv_narrow_i(inv_n), .inv_wide_i(inv_w),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

// ===== tb/sv/gfed_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfed_checker
// Watches both channels and the register port of the erasure decoder, keeps
// its own copy of configuration and inverse, predicts every recovered chunk
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module gfed_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  gfed_pkg::in_item_t  in_data_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  gfed_pkg::out_item_t out_data_o,
  output int                  fail_count_o,
  output int                  pending_o
);
  import gfed_pkg::*;

  logic [1:0]  strings_reg;
  logic [2:0]  rows_reg [3];
  logic [15:0] length_reg;
  logic [15:0] position;
  logic [8:0]  inv_narrow [9];
  logic [8:0]  inv_wide [9];
  bit          sel_bad;
  bit          inv_valid;
  out_item_t   expected_chunks [$];

  // Generator row mask for one coded row bit, written from the code tables.
  function automatic logic [8:0] row_mask(bit three, int width, int row, int b);
    logic [8:0] w3 [5][3] = '{'{1, 2, 4}, '{8, 16, 32}, '{64, 128, 256},
                              '{73, 146, 292}, '{83, 166, 287}};
    logic [8:0] n3 [5][2] = '{'{1, 2}, '{4, 8}, '{16, 32}, '{21, 42}, '{27, 45}};
    logic [8:0] w2 [4][3] = '{'{1, 2, 4}, '{8, 16, 32}, '{9, 18, 36}, '{10, 20, 35}};
    logic [8:0] n2 [4][2] = '{'{1, 2}, '{4, 8}, '{5, 10}, '{6, 11}};
    if (!three) return (width == 3) ? w2[row % 4][b] : n2[row % 4][b];
    return (width == 3) ? w3[row % 5][b] : n3[row % 5][b];
  endfunction

  function automatic bit gauss_invert(bit three, int width, output logic [8:0] inv [9]);
    int n;
    logic [17:0] aug [9];
    logic [17:0] t;
    int piv;
    n = (three ? 3 : 2) * width;
    for (int k = 0; k < 9; k++) inv[k] = '0;
    for (int k = 0; k < n; k++)
      aug[k] = 18'(row_mask(three, width, rows_reg[k / width], k % width))
             | (18'(1) << (k + n));
    for (int c = 0; c < n; c++) begin
      piv = n;
      for (int r = n - 1; r >= c; r--) if (aug[r][c]) piv = r;
      if (piv == n) return 0;
      t = aug[piv]; aug[piv] = aug[c]; aug[c] = t;
      for (int r = 0; r < n; r++) if (r != c && aug[r][c]) aug[r] ^= aug[c];
    end
    for (int k = 0; k < n; k++) inv[k] = 9'((aug[k] >> n) & ((18'(1) << n) - 1));
    return 1;
  endfunction

  function automatic out_item_t decode_chunk(in_item_t rx);
    out_item_t res;
    bit three;
    int width, limit;
    logic [8:0] y;
    logic [2:0] d [3];
    logic [2:0] rv [3];
    logic [16:0] reach;
    three = (strings_reg != 2'd2);
    limit = three ? 5 : 4;
    if (!inv_valid) begin
      sel_bad = 0;
      for (int i = 0; i < (three ? 3 : 2); i++) if (rows_reg[i] >= limit) sel_bad = 1;
      if (!sel_bad) begin
        if (!gauss_invert(three, 2, inv_narrow)) sel_bad = 1;
        if (!gauss_invert(three, 3, inv_wide)) sel_bad = 1;
      end
      inv_valid = 1;
    end
    width = (17'(position) + 3 == 17'(length_reg)) ? 3 : 2;
    reach = 17'(position) + 17'(width);
    rv = '{rx.recv_first, rx.recv_second, rx.recv_third};
    d = '{3'd0, 3'd0, 3'd0};
    y = '0;
    if (!sel_bad) begin
      for (int i = 0; i < (three ? 3 : 2); i++)
        for (int j = 0; j < width; j++) y[i * width + j] = rv[i][j];
      for (int i = 0; i < (three ? 3 : 2); i++)
        for (int j = 0; j < width; j++)
          d[i][j] = ^((width == 3 ? inv_wide[i * width + j] : inv_narrow[i * width + j]) & y);
    end
    res.data_first  = d[0];
    res.data_second = d[1];
    res.data_third  = d[2];
    res.chunk_wide  = (width == 3);
    res.last_chunk  = (reach >= 17'(length_reg));
    res.singular    = sel_bad;
    position = res.last_chunk ? 16'd0 : reach[15:0];
    return res;
  endfunction

  assign pending_o = expected_chunks.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_chunk;
    if (!rst_ni) begin
      strings_reg = 2'd3;
      rows_reg = '{3'd0, 3'd1, 3'd2};
      length_reg = 16'd2;
      position = '0;
      sel_bad = 0;
      inv_valid = 0;
      fail_count_o = 0;
      expected_chunks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DATA_STRINGS: strings_reg = pwdata[1:0];
          REG_ROW_FIRST:    rows_reg[0] = pwdata[2:0];
          REG_ROW_SECOND:   rows_reg[1] = pwdata[2:0];
          REG_ROW_THIRD:    rows_reg[2] = pwdata[2:0];
          REG_MESSAGE_BITS: length_reg = pwdata[15:0];
          default: ;
        endcase
        inv_valid = 0;
        position = '0;
      end
      if (in_valid_i && !in_stall_o) expected_chunks.push_back(decode_chunk(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_chunks.size() == 0) begin
          $error("unexpected result transfer %h", out_data_o);
          fail_count_o++;
        end else begin
          exp_chunk = expected_chunks.pop_front();
          if (out_data_o.data_first !== exp_chunk.data_first) begin
            $error("data_first expected %0d actual %0d", exp_chunk.data_first,
                   out_data_o.data_first);
            fail_count_o++;
          end
          if (out_data_o.data_second !== exp_chunk.data_second) begin
            $error("data_second expected %0d actual %0d", exp_chunk.data_second,
                   out_data_o.data_second);
            fail_count_o++;
          end
          if (out_data_o.data_third !== exp_chunk.data_third) begin
            $error("data_third expected %0d actual %0d", exp_chunk.data_third,
                   out_data_o.data_third);
            fail_count_o++;
          end
          if (out_data_o.chunk_wide !== exp_chunk.chunk_wide) begin
            $error("chunk_wide expected %0d actual %0d", exp_chunk.chunk_wide,
                   out_data_o.chunk_wide);
            fail_count_o++;
          end
          if (out_data_o.last_chunk !== exp_chunk.last_chunk) begin
            $error("last_chunk expected %0d actual %0d", exp_chunk.last_chunk,
                   out_data_o.last_chunk);
            fail_count_o++;
          end
          if (out_data_o.singular !== exp_chunk.singular) begin
            $error("singular expected %0d actual %0d", exp_chunk.singular,
                   out_data_o.singular);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register settings and chunk streams into the erasure decoder under
// varying idle and stall patterns; the checker does all comparison.
// ----------------------------------------------------------------------------
module testbench;
  import gfed_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  out_item_t   out_data_o;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  bit          hold_off_req = 0;

  always #2 clk_i = ~clk_i;

  gf2_erasure_decoder_unit dut (.*);

  gfed_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_off_req) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain_results();
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_code(int strings, int r0, int r1, int r2, int length);
    drain_results();
    reg_write(REG_DATA_STRINGS, strings);
    reg_write(REG_ROW_FIRST, r0);
    reg_write(REG_ROW_SECOND, r1);
    reg_write(REG_ROW_THIRD, r2);
    reg_write(REG_MESSAGE_BITS, length);
  endtask

  task automatic send_chunk(in_item_t chunk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= chunk;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_burst(int count);
    for (int k = 0; k < count; k++) send_chunk(9'($urandom));
    in_valid_i <= 0;
  endtask

  initial begin
    #200000;
    $display("gf2_erasure_decoder_unit verification failed");
    $finish;
  end

  initial begin
    int ph;
    int rws [3];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // Directed: default code, extremes of fields, a wide last chunk.
    send_chunk(9'h000); send_chunk(9'h1FF); send_chunk(9'h0AA); send_chunk(9'h155);
    in_valid_i <= 0;
    set_code(3, 3, 4, 1, 5);
    send_chunk(9'h1FF); send_chunk(9'h000); send_chunk(9'h123); send_chunk(9'h0DE);
    in_valid_i <= 0;
    set_code(2, 2, 3, 7, 3);              // three-bit single chunk, two strings
    send_chunk(9'h1FF); send_chunk(9'h049);
    in_valid_i <= 0;
    set_code(3, 1, 1, 2, 7);              // repeated row
    send_chunk(9'h1FF); send_chunk(9'h0F0);
    in_valid_i <= 0;
    set_code(0, 0, 5, 2, 0);              // bad row index, short message
    send_chunk(9'h1FF);
    in_valid_i <= 0;
    set_code(2, 4, 0, 1, 1);              // row out of range for two strings
    send_chunk(9'h1FF);
    in_valid_i <= 0;
    set_code(1, 4, 3, 0, 65535);
    send_chunk(9'h1FF); send_chunk(9'h0A5);
    in_valid_i <= 0;
    drain_results();
    reg_write(3'd7, 32'hFFFF_FFFF);       // write beyond the register list
    send_chunk(9'h1B6);
    in_valid_i <= 0;
    // Random phases through the idle patterns.
    for (ph = 0; ph < 28; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int i = 0; i < 3; i++) rws[i] = $urandom_range(4);
      if ($urandom_range(9) == 0) rws[$urandom_range(2)] = $urandom_range(7);
      set_code($urandom_range(3), rws[0], rws[1], rws[2],
               ($urandom_range(5) == 0) ? $urandom_range(65535) : $urandom_range(13));
      if (ph == 6) begin
        hold_off_req = 1;
        fork
          send_burst(24);
          begin repeat (80) @(posedge clk_i); hold_off_req = 0; end
        join
      end else begin
        send_burst(12);
        while (pending != 0) @(posedge clk_i);   // sender pauses till all results are in
        send_burst(12);
      end
    end
    recv_stall_pct = 0;
    drain_results();
    if (fail_count == 0) $display("gf2_erasure_decoder_unit verification clean");
    else $display("gf2_erasure_decoder_unit verification failed");
    $finish;
  end
endmodule
